// ===== design/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// shared types, constants and the crc-8 byte update for the frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

	localparam int RAW_W  = 20;
	localparam int TEMP_W = 19;
	localparam int HUM_W  = 17;
	localparam int POS_W  = 3;

	// crc-8, poly 0x31, init 0xff, msb first, no final xor
	localparam logic [7:0] CRC_INIT  = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'h31;
	localparam int         BUSY_BIT  = 7;

	// byte positions inside the seven-byte reply
	localparam logic [POS_W-1:0] POS_IDLE     = 3'd0;
	localparam logic [POS_W-1:0] POS_HUM_HI   = 3'd1;
	localparam logic [POS_W-1:0] POS_HUM_MID  = 3'd2;
	localparam logic [POS_W-1:0] POS_HUM_TEMP = 3'd3;
	localparam logic [POS_W-1:0] POS_TEMP_MID = 3'd4;
	localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd5;
	localparam logic [POS_W-1:0] POS_CRC      = 3'd6;

	// scaling
	localparam logic [16:0]              HUM_SCALE   = 17'd100000;
	localparam logic [17:0]              TEMP_SCALE  = 18'd200000;
	localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 19'sd50000;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_CRC_ERR = 2'd2
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [RAW_W-1:0]   raw_hum;
		logic [RAW_W-1:0]   raw_temp;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7])
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/humidity_temp_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// decodes the seven-byte humidity/temperature measurement reply, checks its
// crc-8 and gives one status / humidity / temperature word per complete reply
// ----------------------------------------------------------------------------
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   [7:0] rx_byte                           [0] frame_start
//   m_axis    out  [18:0] temp_mdeg (signed),              [1:0] read_status
//                  [35:19] humidity_milli_pct, [39:36] 0
//
// - one input word per cycle while s_axis_tready is high; every byte passes an
//   input register, the frame logic and, for the checksum byte only, a result
//   register and the scaling multipliers into the output register
// - a checksum byte waits in the input register only while the result and
//   output registers both hold untaken words; otherwise bytes keep flowing
// - arst_n clears position, crc (to 0xff), busy flag, raw fields and valids
//
`default_nettype none

module humidity_temp_frame_decoder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input bytes
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	input  wire logic         s_axis_tuser,   // [0] frame_start
	// decoded results
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [39:0]       m_axis_tdata,   // [18:0] temp_mdeg, [35:19] humidity_milli_pct
	output logic [1:0]        m_axis_tuser    // [1:0] read_status
);
	import htfd_pkg::*;

	// frame stage to conversion stage
	logic                      res_valid;
	logic                      res_take;
	frame_t                    res;

	// output register contents
	status_t                   read_status;
	logic signed [TEMP_W-1:0]  temp_mdeg;
	logic [HUM_W-1:0]          humidity_milli_pct;

	// byte position tracking, crc and raw field capture
	htfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_start  (s_axis_tuser),
		.res_take  (res_take),
		.res_valid (res_valid),
		.res       (res)
	);

	// scaling to milli-units and output register
	htfd_convert u_convert (
		.clk                (clk),
		.arst_n             (arst_n),
		.res_valid          (res_valid),
		.res                (res),
		.res_take           (res_take),
		.out_valid          (m_axis_tvalid),
		.out_ready          (m_axis_tready),
		.read_status        (read_status),
		.temp_mdeg          (temp_mdeg),
		.humidity_milli_pct (humidity_milli_pct)
	);

	// pack the output word, pad to whole bytes
	assign m_axis_tdata = {4'h0, humidity_milli_pct, temp_mdeg};
	assign m_axis_tuser = read_status;

endmodule

`default_nettype wire

// ===== design/htfd_frame.sv =====
// ----------------------------------------------------------------------------
// htfd_frame
// input register, byte tracking, running crc and raw field capture
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_frame (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_start,
	input  wire logic            res_take,
	output logic                 res_valid,
	output htfd_pkg::frame_t     res
);
	import htfd_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;

	logic [POS_W-1:0]  pos_q;
	logic [7:0]        crc_q;
	logic              busy_q;
	logic [RAW_W-1:0]  raw_hum_q;
	logic [RAW_W-1:0]  raw_temp_q;

	logic              valid_s2;
	frame_t            res_s2;

	logic              last;
	logic              s2_free;
	logic              go;
	logic [7:0]        crc_next;
	status_t           status;

	assign last     = !start_s1 && (pos_q == POS_CRC);
	assign s2_free  = !valid_s2 || res_take;
	assign go       = valid_s1 && (!last || s2_free);
	assign in_ready = !valid_s1 || go;
	assign crc_next = crc8_byte(start_s1 ? CRC_INIT : crc_q, byte_s1);

	always_comb begin
		if (busy_q)
			status = ST_BUSY;
		else if (crc_q != byte_s1)
			status = ST_CRC_ERR;
		else
			status = ST_OK;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			start_s1 <= in_start;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_IDLE;
			crc_q      <= CRC_INIT;
			busy_q     <= 1'b0;
			raw_hum_q  <= '0;
			raw_temp_q <= '0;
		end else if (go) begin
			if (start_s1) begin
				crc_q  <= crc_next;
				busy_q <= byte_s1[BUSY_BIT];
				pos_q  <= POS_HUM_HI;
			end else begin
				case (pos_q)
					POS_HUM_HI: begin
						crc_q     <= crc_next;
						raw_hum_q <= {byte_s1, 12'h000};
						pos_q     <= POS_HUM_MID;
					end
					POS_HUM_MID: begin
						crc_q     <= crc_next;
						raw_hum_q <= raw_hum_q | {8'h00, byte_s1, 4'h0};
						pos_q     <= POS_HUM_TEMP;
					end
					POS_HUM_TEMP: begin
						crc_q      <= crc_next;
						raw_hum_q  <= raw_hum_q | {16'h0000, byte_s1[7:4]};
						raw_temp_q <= {byte_s1[3:0], 16'h0000};
						pos_q      <= POS_TEMP_MID;
					end
					POS_TEMP_MID: begin
						crc_q      <= crc_next;
						raw_temp_q <= raw_temp_q | {4'h0, byte_s1, 8'h00};
						pos_q      <= POS_TEMP_LO;
					end
					POS_TEMP_LO: begin
						crc_q      <= crc_next;
						raw_temp_q <= raw_temp_q | {12'h000, byte_s1};
						pos_q      <= POS_CRC;
					end
					default: begin
						// checksum byte, idle or the unused code: back to idle
						pos_q <= POS_IDLE;
					end
				endcase
			end
		end
	end

	// result register toward the conversion stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go && last) begin
			valid_s2 <= 1'b1;
		end else if (res_take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last) begin
			res_s2.status   <= status;
			res_s2.raw_hum  <= raw_hum_q;
			res_s2.raw_temp <= raw_temp_q;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

// ===== design/htfd_convert.sv =====
// ----------------------------------------------------------------------------
// htfd_convert
// scales raw fields to milli-units and holds the output register
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_convert (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          res_valid,
	input  wire htfd_pkg::frame_t              res,
	output logic                               res_take,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output htfd_pkg::status_t                  read_status,
	output logic signed [htfd_pkg::TEMP_W-1:0] temp_mdeg,
	output logic [htfd_pkg::HUM_W-1:0]         humidity_milli_pct
);
	import htfd_pkg::*;

	localparam int HUM_PW  = RAW_W + 17;
	localparam int TEMP_PW = RAW_W + 18;

	logic [HUM_PW-1:0]          hum_prod;
	logic [TEMP_PW-1:0]         temp_prod;
	logic signed [TEMP_W-1:0]   temp_val;

	logic                       valid_q;
	status_t                    status_q;
	logic signed [TEMP_W-1:0]   temp_q;
	logic [HUM_W-1:0]           hum_q;

	assign hum_prod  = HUM_PW'(res.raw_hum) * HUM_PW'(HUM_SCALE);
	assign temp_prod = TEMP_PW'(res.raw_temp) * TEMP_PW'(TEMP_SCALE);
	assign temp_val  = $signed({1'b0, temp_prod[TEMP_PW-1:RAW_W]}) - TEMP_OFFSET;

	assign res_take = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			status_q <= res.status;
			if (res.status == ST_OK) begin
				temp_q <= temp_val;
				hum_q  <= hum_prod[HUM_PW-1:RAW_W];
			end else begin
				temp_q <= '0;
				hum_q  <= '0;
			end
		end
	end

	assign out_valid          = valid_q;
	assign read_status        = status_q;
	assign temp_mdeg          = temp_q;
	assign humidity_milli_pct = hum_q;

endmodule

`default_nettype wire

// ===== design/htfd_checker.sv =====
// ----------------------------------------------------------------------------
// htfd_checker
// port-level checks for the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,
	input  wire logic         s_axis_tuser,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [39:0]  m_axis_tdata,
	input  wire logic [1:0]   m_axis_tuser
);
	import htfd_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// busy and checksum errors carry zero measurements
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == 40'd0))
		else $error("non-ok result with nonzero data");

	// scaled humidity stays below 100 percent, pad bits stay clear
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[35:19] < 17'd100000) && (m_axis_tdata[39:36] == 4'h0))
		else $error("humidity out of range or pad bits set");

	// a ready output side never holds back the input side
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output ready");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// feeds seven-byte sensor replies through the frame decoder and checks
// every decoded reading against a cycle-free prediction of the reply decode
// ----------------------------------------------------------------------------
//
// - a short directed run covers the extreme readings, a busy reply with a
//   bad checksum, a stray byte while idle and a restart in mid reply
// - the random run is mostly well-formed replies with random content, mixed
//   with busy replies, checksum errors, cut replies and stray bytes
// - both sides stall in random bursts; the tail of the run has no stalls
//
module tb_top;

	import htfd_pkg::*;

	localparam logic [7:0] POLY_CRC8 = 8'h31;
	localparam logic [7:0] SEED_CRC8 = 8'hFF;
	localparam longint    HUM_SPAN  = 100000;
	localparam longint    TEMP_SPAN = 200000;
	localparam longint    TEMP_BASE = 50000;
	localparam int        RAND_BYTES = 2000;
	localparam int        CALM_AFTER = 1800;

	// one decoded reading as it leaves the block
	typedef struct packed {
		status_t            status;
		logic signed [18:0] temp;
		logic [16:0]        hum;
	} reading_t;

	// a whole reply, byte 0 (status) in the lowest bits
	typedef logic [6:0][7:0] reply_t;

	// tracks the reply decode and holds the readings still owed by the block
	class reading_tracker;
		logic [2:0]  pos;
		logic [7:0]  crc;
		logic        busy;
		logic [19:0] raw_hum;
		logic [19:0] raw_temp;
		reading_t    readings_due[$];
		int          bad_readings;

		function new();
			pos = POS_IDLE;
			crc = SEED_CRC8;
			busy = 1'b0;
			raw_hum = '0;
			raw_temp = '0;
			bad_readings = 0;
		endfunction

		// bit-serial form of the crc-8 update, msb first
		static function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] b);
			logic [7:0] c;
			logic       fb;
			c = acc;
			for (int i = 7; i >= 0; i--) begin
				fb = c[7] ^ b[i];
				c = {c[6:0], 1'b0};
				if (fb)
					c = c ^ POLY_CRC8;
			end
			return c;
		endfunction

		function void take_byte(logic [7:0] b, logic start);
			reading_t   r;
			logic [63:0] h_full;
			logic [63:0] t_full;
			longint      t;
			if (start) begin
				crc = crc_step(SEED_CRC8, b);
				busy = b[7];
				pos = POS_HUM_HI;
			end else if (pos >= POS_HUM_HI && pos <= POS_TEMP_LO) begin
				crc = crc_step(crc, b);
				case (pos)
					POS_HUM_HI:   raw_hum = {b, 12'h000};
					POS_HUM_MID:  raw_hum = raw_hum | {8'h00, b, 4'h0};
					POS_HUM_TEMP: begin
						raw_hum = raw_hum | {16'h0000, b[7:4]};
						raw_temp = {b[3:0], 16'h0000};
					end
					POS_TEMP_MID: raw_temp = raw_temp | {4'h0, b, 8'h00};
					default:      raw_temp = raw_temp | {12'h000, b};
				endcase
				pos = pos + 3'd1;
			end else if (pos == POS_CRC) begin
				// checksum byte closes the reply; busy wins over a bad crc
				pos = POS_IDLE;
				r = '0;
				if (busy)
					r.status = ST_BUSY;
				else if (crc != b)
					r.status = ST_CRC_ERR;
				else begin
					h_full = 64'(raw_hum) * 64'(HUM_SPAN);
					t_full = 64'(raw_temp) * 64'(TEMP_SPAN);
					t = longint'(t_full >> 20) - TEMP_BASE;
					r.status = ST_OK;
					r.temp = t[18:0];
					r.hum = h_full[36:20];
				end
				readings_due.push_back(r);
			end else begin
				// idle: a byte without start is dropped
				pos = POS_IDLE;
			end
		endfunction

		function void check_reading(logic [1:0] status, logic [18:0] temp, logic [16:0] hum);
			reading_t want;
			if (readings_due.size() == 0) begin
				bad_readings++;
				if (bad_readings <= 10)
					$display("%0t: word with no reading due: status %0d temp %0d hum %0d",
						$realtime, status, $signed(temp), hum);
				return;
			end
			want = readings_due.pop_front();
			if (status != want.status || temp != want.temp || hum != want.hum) begin
				bad_readings++;
				if (bad_readings <= 10)
					$display("%0t: reading mismatch: status %0d/%0d temp %0d/%0d hum %0d/%0d (exp/got)",
						$realtime, want.status, status, want.temp, $signed(temp),
						want.hum, hum);
			end
		endfunction

		function int pending();
			return readings_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic        s_axis_tuser;   // [0] frame_start
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [18:0] temp_mdeg, [35:19] humidity_milli_pct
	logic [1:0]  m_axis_tuser;   // [1:0] read_status

	reading_tracker tracker = new();

	// stall control
	bit calm;        // tail of the run: no stalls on either side
	bit quiet_tx;    // stretch with no sender gaps
	int rx_hold;

	humidity_temp_frame_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#20_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// receiver: random stall bursts, always ready in the tail
	always @(negedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			rx_hold = $urandom_range(1, 19) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// every word taken from the block is checked at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_reading(m_axis_tuser, m_axis_tdata[18:0], m_axis_tdata[35:19]);
	end

	// drive one byte and wait for its handshake; returns on a falling edge
	task automatic send_byte(input logic [7:0] b, input logic start);
		int gap;
		if (!calm && !quiet_tx && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.take_byte(b, start);
		@(negedge clk);
	endtask

	// first count bytes of a reply, start flag on byte 0
	task automatic send_reply(input reply_t r, input int count);
		for (int i = 0; i < count; i++)
			send_byte(r[i], i == 0);
	endtask

	// hold the sender until every owed reading has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (tracker.pending() != 0);
	endtask

	function automatic reply_t seal(input reply_t r);
		logic [7:0] c;
		c = SEED_CRC8;
		for (int i = 0; i < 6; i++)
			c = reading_tracker::crc_step(c, r[i]);
		r[6] = c;
		return r;
	endfunction

	initial begin
		reply_t r;
		int     sent;
		int     pick;
		int     cut;
		bit     drained;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		calm = 1'b0;
		quiet_tx = 1'b0;
		rx_hold = 0;
		sent = 0;
		drained = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: stray byte while idle is ignored
		send_byte(8'hA5, 1'b0);
		// all-zero reply: lowest temperature, zero humidity
		send_reply(seal('0), 7);
		// byte without start right after a complete reply
		send_byte(8'h5A, 1'b0);
		// reply cut after its status byte, then restarted
		send_byte(8'h00, 1'b1);
		// all-ones data, busy clear: top of both ranges
		r = '1;
		r[0] = 8'h7F;
		send_reply(seal(r), 7);
		// busy with a bad checksum: busy must win
		r = seal('1);
		r[6] = ~r[6];
		send_reply(r, 7);
		drain();

		// random replies
		while (sent < RAND_BYTES) begin
			if (sent >= CALM_AFTER)
				calm = 1'b1;
			if ($urandom_range(0, 15) == 0)
				quiet_tx = ($urandom_range(0, 2) == 0);
			if (!drained && sent >= RAND_BYTES / 2) begin
				drain();
				drained = 1'b1;
			end
			// stray bytes between replies (or into a cut one)
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(0, 255)), 1'b0);
			for (int i = 0; i < 7; i++)
				r[i] = 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				r[0][7] = 1'b0;
				send_reply(seal(r), 7);
				sent += 7;
			end else if (pick < 75) begin
				// busy, checksum right or wrong
				r[0][7] = 1'b1;
				if ($urandom_range(0, 1) == 0)
					r = seal(r);
				send_reply(r, 7);
				sent += 7;
			end else if (pick < 90) begin
				// checksum error: flip a nonzero pattern
				r[0][7] = 1'b0;
				r = seal(r);
				r[6] = r[6] ^ 8'($urandom_range(1, 255));
				send_reply(r, 7);
				sent += 7;
			end else begin
				// reply cut short; the next start drops it
				cut = $urandom_range(1, 6);
				send_reply(r, cut);
				sent += cut;
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (tracker.bad_readings == 0 && tracker.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
